>>> rtl/srdc_pkg.sv
// Shared types, codes and constant tables for the serial relay / DAC command parser.
// No dependencies; imported by srdc_fsm and the top level.
`default_nettype none

package srdc_pkg;

  localparam int INIT_LEN = 32;
  localparam int MAP_LEN  = 68;
  localparam int INIT_IW  = (INIT_LEN > 1) ? $clog2(INIT_LEN) : 1;

  localparam logic [7:0] BYTE_HDR    = 8'h55;
  localparam logic [7:0] BYTE_END    = 8'h56;
  localparam logic [7:0] BYTE_NOP    = 8'h57;
  localparam logic [7:0] BYTE_REPLAY = 8'h58;
  localparam logic [7:0] CODE_DAC_WR = 8'h01;
  localparam logic [7:0] MAP_NONE    = 8'hFF;

  localparam logic [7:0] MODE_NONE   = 8'h00;
  localparam logic [7:0] MODE_SWITCH = 8'h73;
  localparam logic [7:0] MODE_DAC    = 8'h64;
  localparam logic [7:0] MODE_PASS   = 8'h6E;
  localparam logic [7:0] MODE_PORT   = 8'h74;

  localparam logic [2:0] FRAME_LEN = 3'd4;   // count value of the DAC code byte
  localparam int         FB_DEPTH  = 3;
  localparam int         FB_AW     = 2;

  localparam logic [7:0] MAP_TAB [68] = '{
    8'd43, 8'd47, 8'd31, 8'd255, 8'd19, 8'd17, 8'd23, 8'd21,
    8'd46, 8'd42, 8'd255, 8'd30, 8'd16, 8'd18, 8'd20, 8'd22,
    8'd41, 8'd57, 8'd45, 8'd255, 8'd0, 8'd255, 8'd2, 8'd54,
    8'd56, 8'd40, 8'd255, 8'd44, 8'd255, 8'd1, 8'd55, 8'd3,
    8'd4, 8'd27, 8'd63, 8'd6, 8'd35, 8'd33, 8'd39, 8'd37,
    8'd26, 8'd5, 8'd7, 8'd62, 8'd32, 8'd34, 8'd36, 8'd38,
    8'd61, 8'd59, 8'd25, 8'd29, 8'd9, 8'd11, 8'd13, 8'd15,
    8'd58, 8'd60, 8'd28, 8'd24, 8'd10, 8'd8, 8'd14, 8'd12,
    8'd49, 8'd48, 8'd51, 8'd50
  };

  localparam logic [7:0] INIT_TAB [32] = '{
    8'h37, 8'h36, 8'h35, 8'h3D, 8'h33, 8'h32, 8'h31, 8'h30,
    8'h26, 8'h27, 8'h24, 8'h25, 8'h22, 8'h23, 8'h20, 8'h21,
    8'h17, 8'h16, 8'h15, 8'h14, 8'h13, 8'h12, 8'h11, 8'h10,
    8'h06, 8'h07, 8'h04, 8'h05, 8'h02, 8'h0A, 8'h00, 8'h01
  };

  typedef enum logic [2:0] {
    KIND_HOST    = 3'd0,
    KIND_LINK    = 3'd1,
    KIND_RELAY   = 3'd2,
    KIND_PORT    = 3'd3,
    KIND_DAC_WR  = 3'd4,
    KIND_DAC_CMD = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_DATA,
    S_ACK,
    S_REPLAY
  } state_t;

  typedef enum logic [3:0] {
    A_IGNORE,
    A_ECHO,
    A_SESS_END,
    A_REPLAY,
    A_PULSE,
    A_PORT_END,
    A_FRAME_ACC,
    A_DAC_BAD,
    A_DAC_WR,
    A_DAC_CMD,
    A_SET_MODE,
    A_HEADER,
    A_OPEN_SESS,
    A_DAC_START,
    A_PASS,
    A_PORT_START
  } act_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic       last;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [FB_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic [FB_AW-1:0] raddr;
  } fb_req_t;

  function automatic logic [7:0] map_raw(input logic [7:0] idx);
    logic [7:0] r;
    r = 8'd0;
    if (idx < 8'd68) begin
      r = MAP_TAB[idx[6:0]];
    end
    return r;
  endfunction

  function automatic logic [7:0] map_entry(input logic [7:0] idx);
    logic [7:0] r;
    r = MAP_NONE;
    if ({1'b0, idx} < 9'(MAP_LEN)) begin
      r = map_raw(idx);
    end
    return r;
  endfunction

  function automatic logic pulse_valid(input logic [7:0] idx);
    return map_entry(idx) != MAP_NONE;
  endfunction

  function automatic res_t pulse_res(input logic [7:0] idx, input logic fin);
    logic [7:0] e;
    res_t       r;
    e             = map_entry(idx);
    r.kind        = KIND_RELAY;
    r.first_byte  = ~(8'h80 >> e[5:3]);
    r.second_byte = ~(8'h80 >> e[2:0]);
    r.third_byte  = 8'd0;
    r.last        = fin;
    return r;
  endfunction

  function automatic logic [7:0] init_raw(input logic [5:0] idx);
    logic [7:0] r;
    r = 8'd0;
    if (idx < 6'd32) begin
      r = INIT_TAB[idx[4:0]];
    end
    return r;
  endfunction

  // index of the final replay entry that produces a pulse (-1 if none)
  function automatic int init_last_valid();
    int r;
    r = -1;
    for (int i = 0; i < INIT_LEN; i++) begin
      if (pulse_valid(init_raw(6'(i)))) begin
        r = i;
      end
    end
    return r;
  endfunction

  localparam int INIT_LAST = init_last_valid();

endpackage

`default_nettype wire

>>> rtl/srdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/srdc_fsm.sv
// Command parser sequencer: decodes one received byte, keeps the mode and frame state,
// keeps frame data bytes in the frame RAM and produces results. Depends on srdc_pkg.
`default_nettype none

module srdc_fsm import srdc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_source,
  input  wire logic [7:0] in_byte,
  output logic            in_ready,
  input  wire logic       out_free,
  output logic            res_valid,
  output res_t            res,
  output fb_req_t         fb_req,
  input  wire logic [7:0] fb_rdata
);

  state_t state, state_next;
  act_t   act;

  logic [7:0]         mode_code;
  logic               header_pending;
  logic               switch_session;
  logic [2:0]         frame_count;
  logic [7:0]         frame_sum;
  logic               ack_pending;
  logic               ack_code;
  logic [1:0]         ack_idx;
  logic [INIT_IW-1:0] replay_idx;
  logic               rd_port;

  logic       src_q;
  logic [7:0] byte_q;
  logic [7:0] fb0;
  logic [7:0] fb1;
  res_t       data_res;

  logic [7:0] sum_new;
  logic [7:0] rep_byte;
  logic       rep_valid;
  logic       rep_end;

  assign sum_new   = frame_sum + byte_q;
  assign rep_byte  = init_raw(6'(replay_idx));
  assign rep_valid = pulse_valid(rep_byte);
  assign rep_end   = (replay_idx == INIT_IW'(INIT_LEN - 1));

  // classify the latched byte
  always_comb begin
    act = A_IGNORE;
    if (src_q) begin
      act = A_ECHO;
    end else if (switch_session) begin
      if (byte_q == BYTE_END) begin
        act = A_SESS_END;
      end else if (byte_q == BYTE_REPLAY) begin
        act = A_REPLAY;
      end else if (byte_q == BYTE_NOP) begin
        act = A_IGNORE;
      end else if (pulse_valid(byte_q)) begin
        act = A_PULSE;
      end
    end else if (frame_count != 3'd0) begin
      if (mode_code == MODE_PORT) begin
        act = A_PORT_END;
      end else if (frame_count < FRAME_LEN) begin
        act = A_FRAME_ACC;
      end else if (sum_new != 8'd0) begin
        act = A_DAC_BAD;
      end else if (byte_q == CODE_DAC_WR) begin
        act = A_DAC_WR;
      end else begin
        act = A_DAC_CMD;
      end
    end else if (header_pending && byte_q != BYTE_HDR) begin
      act = A_SET_MODE;
    end else if (!header_pending && byte_q == BYTE_HDR) begin
      act = A_HEADER;
    end else begin
      case (mode_code)
        MODE_SWITCH: act = (byte_q == BYTE_HDR) ? A_OPEN_SESS : A_IGNORE;
        MODE_DAC:    act = A_DAC_START;
        MODE_PASS:   act = A_PASS;
        MODE_PORT:   act = A_PORT_START;
        default:     act = A_IGNORE;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (act)
          A_ECHO, A_PULSE, A_DAC_CMD, A_PASS: state_next = S_DATA;
          A_SESS_END, A_DAC_BAD:              state_next = S_ACK;
          A_REPLAY:                           state_next = S_REPLAY;
          A_PORT_END, A_DAC_WR:               state_next = S_RD0;
          default:                            state_next = S_IDLE;
        endcase
      end
      S_RD0: state_next = rd_port ? S_DATA : S_RD1;
      S_RD1: state_next = S_RD2;
      S_RD2: state_next = S_DATA;
      S_DATA: begin
        if (out_free) state_next = ack_pending ? S_ACK : S_IDLE;
      end
      S_ACK: begin
        if (out_free && ack_idx == 2'd3) state_next = S_IDLE;
      end
      S_REPLAY: begin
        if ((!rep_valid || out_free) && rep_end) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == S_IDLE);
    res_valid    = 1'b0;
    res          = data_res;
    fb_req.we    = (state == S_DECODE) && (act == A_FRAME_ACC || act == A_PORT_START);
    fb_req.waddr = (act == A_FRAME_ACC) ? FB_AW'(frame_count - 3'd1) : '0;
    fb_req.wdata = byte_q;
    fb_req.raddr = '0;
    case (state)
      S_RD0: fb_req.raddr = FB_AW'(1);
      S_RD1: fb_req.raddr = FB_AW'(2);
      S_DATA: begin
        res_valid = 1'b1;
        res.last  = !ack_pending;
      end
      S_ACK: begin
        res_valid       = 1'b1;
        res.kind        = KIND_HOST;
        res.second_byte = 8'd0;
        res.third_byte  = 8'd0;
        res.last        = (ack_idx == 2'd3);
        case (ack_idx)
          2'd0:    res.first_byte = BYTE_HDR;
          2'd3:    res.first_byte = BYTE_END;
          default: res.first_byte = {7'd0, ack_code};
        endcase
      end
      S_REPLAY: begin
        res_valid = rep_valid;
        res       = pulse_res(rep_byte, replay_idx == INIT_IW'(INIT_LAST));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mode_code      <= MODE_NONE;
      header_pending <= 1'b0;
      switch_session <= 1'b0;
      frame_count    <= 3'd0;
      frame_sum      <= 8'd0;
      ack_pending    <= 1'b0;
      ack_code       <= 1'b0;
      ack_idx        <= 2'd0;
      replay_idx     <= '0;
      rd_port        <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_DECODE: begin
          ack_idx     <= 2'd0;
          replay_idx  <= '0;
          ack_code    <= (act == A_DAC_BAD);
          ack_pending <= (act == A_PORT_END || act == A_DAC_WR || act == A_DAC_CMD);
          rd_port     <= (act == A_PORT_END);
          if (!src_q && !switch_session && frame_count == 3'd0) begin
            header_pending <= (act == A_HEADER);
          end
          case (act)
            A_SESS_END: begin
              switch_session <= 1'b0;
              mode_code      <= MODE_NONE;
            end
            A_PORT_END: begin
              frame_count <= 3'd0;
              mode_code   <= MODE_NONE;
            end
            A_FRAME_ACC: begin
              frame_sum   <= sum_new;
              frame_count <= frame_count + 3'd1;
            end
            A_DAC_BAD, A_DAC_WR, A_DAC_CMD: begin
              frame_sum   <= sum_new;
              frame_count <= 3'd0;
              mode_code   <= MODE_NONE;
            end
            A_SET_MODE:   mode_code <= byte_q;
            A_OPEN_SESS:  switch_session <= 1'b1;
            A_DAC_START: begin
              frame_count <= 3'd1;
              frame_sum   <= byte_q;
            end
            A_PORT_START: frame_count <= 3'd1;
            default: ;
          endcase
        end
        S_ACK: begin
          if (out_free) ack_idx <= ack_idx + 2'd1;
        end
        S_REPLAY: begin
          if (!rep_valid || out_free) replay_idx <= replay_idx + INIT_IW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          src_q  <= in_source;
          byte_q <= in_byte;
        end
      end
      S_DECODE: begin
        case (act)
          A_ECHO:    data_res <= '{KIND_HOST, byte_q, 8'd0, 8'd0, 1'b1};
          A_PASS:    data_res <= '{KIND_LINK, byte_q, 8'd0, 8'd0, 1'b1};
          A_DAC_CMD: data_res <= '{KIND_DAC_CMD, byte_q, 8'd0, 8'd0, 1'b0};
          A_PULSE:   data_res <= pulse_res(byte_q, 1'b1);
          default: ;
        endcase
      end
      S_RD0: begin
        fb0 <= fb_rdata;
        if (rd_port) data_res <= '{KIND_PORT, fb_rdata, byte_q, 8'd0, 1'b0};
      end
      S_RD1: fb1 <= fb_rdata;
      S_RD2: data_res <= '{KIND_DAC_WR, fb0, fb1, fb_rdata, 1'b0};
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/serial_relay_dac_command_parser.sv
// Top level of the serial relay / DAC command parser: stream ports, result register,
// frame data RAM. Depends on srdc_pkg, srdc_ram and srdc_fsm.
//
// Bytes arrive one transaction at a time; tuser says which link sent them. One byte is
// taken at a time: s_tready rises again once every result of the previous byte has
// entered the output register. A port set makes one frame RAM read and a DAC write
// three; a session end or a bad DAC frame gives an ack alone. A relay replay steps
// through the 32 ROM entries (INIT_LEN), one per cycle unless a pulse result waits on
// a full output register. The sequencer moves one result per cycle through the output
// register while m_tready does not stall it. m_tlast marks the last result of each byte.
`default_nettype none

module serial_relay_dac_command_parser import srdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  s_tuser,   // [0] source
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // [7:0] first_byte, [15:8] second_byte, [23:16] third_byte
  output logic      [2:0]  m_tuser,   // [2:0] kind
  output logic             m_tlast
);

  logic       out_free;
  logic       res_valid;
  res_t       res;
  res_t       out_res;
  fb_req_t    fb_req;
  logic [7:0] fb_rdata;

  assign out_free = !m_tvalid || m_tready;

  srdc_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_source (s_tuser[0]),
    .in_byte   (s_tdata),
    .in_ready  (s_tready),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .fb_req    (fb_req),
    .fb_rdata  (fb_rdata)
  );

  srdc_ram #(
    .WIDTH (8),
    .DEPTH (FB_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fb_req.we),
    .waddr (fb_req.waddr),
    .wdata (fb_req.wdata),
    .raddr (fb_req.raddr),
    .rdata (fb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.third_byte, out_res.second_byte, out_res.first_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("byte accepted while previous byte still in progress");

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !res_valid)
    else $error("result produced while waiting for input");

  a_relay_one_hot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_RELAY) |->
      ($onehot(~m_tdata[7:0]) && $onehot(~m_tdata[15:8])))
    else $error("relay pulse pattern not active-low one-hot");

  a_dac_write_acked: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_DAC_WR) |-> !m_tlast)
    else $error("dac write not followed by ack");

endmodule

`default_nettype wire
